// File: design/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, widths and a helper function for the color pair allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam int COLOR_W = 26;
    localparam int PAIR_W  = 10;
    localparam int MAP_W   = 9;
    localparam int CC_W    = 9;
    localparam int PL_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Width of a palette index taken straight from a color code.
    localparam int VAL_W     = 24;
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CIDX_W-1:0] REG_COLOR_COUNT    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PAIR_LIMIT     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_COLORS_ENABLED = 2'd2;

    localparam logic [CC_W-1:0] COLOR_COUNT_RESET = 9'd256;
    localparam logic [PL_W-1:0] PAIR_LIMIT_RESET  = 16'd256;

    localparam logic [VAL_W-1:0] LOW_PALETTE = 24'd16;
    localparam logic [VAL_W-1:0] GRAY_BASE   = 24'd232;
    localparam logic [8:0]       GRAY_DIV    = 9'd247;
    localparam logic [MAP_W-1:0] MAP_DEFAULT = 9'h1FF;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    // Cube level of one 8-bit channel: floor(v * 5 / 255), which is floor(v / 51).
    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] lvl;
        lvl = 3'd0;
        if (v >= 8'd51)  lvl = 3'd1;
        if (v >= 8'd102) lvl = 3'd2;
        if (v >= 8'd153) lvl = 3'd3;
        if (v >= 8'd204) lvl = 3'd4;
        if (v == 8'd255) lvl = 3'd5;
        return lvl;
    endfunction

endpackage

// File: design/color_pair_allocator_top.sv
// ----------------------------------------------------------------------------
// color_pair_allocator_top
// Maps foreground/background color requests to terminal color pair numbers.
// ----------------------------------------------------------------------------
// Usage:
// A beat on the s_ side carries one request (foreground and background color
// codes). A beat on the m_ side returns the resulting pair number, a flag that
// says a new pair was allocated, and the terminal colors of that new pair.
// Configuration beats on the cfg_ channel are always taken; they should only
// be sent while no request is in flight.
// Flow: a request that needs no table lookup goes straight to the output
// state. A lookup scans the pair table one entry per cycle through a single
// registered read port. A newly allocated pair then runs both colors through
// one shared restoring divider (up to two divisions per color). The block
// takes one request at a time and holds s_tready low until the result is in
// the output register.
// The output register lets a new request start while the previous result
// waits; if the receiver stalls, a finished result waits until the register
// frees up. Reset empties the table (next pair is 1), selects pair 0 and loads
// the default configuration; the table memory itself needs no clearing.
// ----------------------------------------------------------------------------
module color_pair_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // fore_color[25:0], back_color[51:26]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // pair_number[9:0], pair_created[10],
                                    // mapped_fore[19:11], mapped_back[28:20]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cpa_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cpa_pkg::CFG_W-1:0]  cfg_data
);

    localparam int ENTRY_W = 2 * cpa_pkg::COLOR_W;

    // Configuration.
    logic [cpa_pkg::CC_W-1:0] color_count_reg;
    logic [cpa_pkg::PL_W-1:0] pair_limit_reg;
    logic                     colors_enabled_reg;

    // Allocator state.
    logic [cpa_pkg::CNT_W-1:0]  next_free_reg;
    logic [cpa_pkg::PAIR_W-1:0] active_reg;

    // Request and sequencer.
    cpa_pkg::state_t             state_reg;
    logic [cpa_pkg::COLOR_W-1:0] fore_reg;
    logic [cpa_pkg::COLOR_W-1:0] back_reg;
    logic                        created_reg;
    logic                        sel_reg;
    logic [cpa_pkg::MAP_W-1:0]   mf_reg;
    logic [cpa_pkg::MAP_W-1:0]   mb_reg;
    logic [cpa_pkg::VAL_W-1:0]   val_reg;

    // Table scan.
    logic [cpa_pkg::CNT_W-1:0] scan_reg;
    logic                      pend_reg;
    logic [cpa_pkg::IDX_W-1:0] pend_idx_reg;
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic [ENTRY_W-1:0]        mem [cpa_pkg::TABLE_DEPTH];

    // Shared divider.
    logic [8:0]                 div_rem_reg;
    logic [cpa_pkg::VAL_W-1:0]  div_quo_reg;
    logic [8:0]                 div_den_reg;
    logic [cpa_pkg::STEP_W-1:0] div_step_reg;
    logic                       div_gray_reg;

    // Output register.
    logic                       m_valid_reg;
    logic [cpa_pkg::PAIR_W-1:0] out_pair_reg;
    logic                       out_created_reg;
    logic [cpa_pkg::MAP_W-1:0]  out_mf_reg;
    logic [cpa_pkg::MAP_W-1:0]  out_mb_reg;

    // Combinational helpers.
    logic                        in_beat;
    logic [cpa_pkg::COLOR_W-1:0] in_fore;
    logic [cpa_pkg::COLOR_W-1:0] in_back;
    logic [cpa_pkg::CNT_W-1:0]   used_cnt;
    logic [cpa_pkg::CNT_W-1:0]   hit_cnt;
    logic                        hit;
    logic                        scan_done;
    logic                        room;
    logic                        mem_we;
    logic [8:0]                  cnt_eff;
    logic [cpa_pkg::COLOR_W-1:0] cur;
    logic [7:0]                  ch_r;
    logic [7:0]                  ch_g;
    logic [7:0]                  ch_b;
    logic                        is_rgb;
    logic                        is_gray;
    logic [7:0]                  cube_idx;
    logic [cpa_pkg::VAL_W-1:0]   gray_dvd;
    logic [9:0]                  div_shift;
    logic                        div_take;
    logic [8:0]                  div_rem_next;
    logic [cpa_pkg::VAL_W-1:0]   div_quo_next;
    logic                        div_last;
    logic                        res_store;
    logic [cpa_pkg::MAP_W-1:0]   res_val;
    logic                        out_load;

    assign in_fore  = s_tdata[cpa_pkg::COLOR_W-1:0];
    assign in_back  = s_tdata[ENTRY_W-1:cpa_pkg::COLOR_W];
    assign s_tready = (state_reg == cpa_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign used_cnt  = next_free_reg - 1'b1;
    assign hit_cnt   = cpa_pkg::CNT_W'(pend_idx_reg) + 1'b1;
    assign hit       = pend_reg && (rd_data_reg == {back_reg, fore_reg});
    assign scan_done = !pend_reg && (scan_reg >= used_cnt);
    assign room      = (cpa_pkg::PL_W'(next_free_reg) < pair_limit_reg)
                    && (next_free_reg < cpa_pkg::CNT_W'(cpa_pkg::TABLE_DEPTH));
    assign mem_we    = (state_reg == cpa_pkg::ST_SEARCH) && scan_done && room;

    // A count of zero behaves as one and anything above 256 as 256.
    always_comb
    begin
        if (color_count_reg == '0)
            cnt_eff = 9'd1;
        else if (color_count_reg > 9'd256)
            cnt_eff = 9'd256;
        else
            cnt_eff = color_count_reg;
    end

    // Color decode for the color currently being mapped.
    assign cur      = sel_reg ? back_reg : fore_reg;
    assign ch_r     = cur[23:16];
    assign ch_g     = cur[15:8];
    assign ch_b     = cur[7:0];
    assign is_rgb   = !cur[25] && cur[24];
    assign is_gray  = (ch_r == ch_g) && (ch_g == ch_b);
    assign cube_idx = 8'd16 + 8'(cpa_pkg::cube_level(ch_r)) * 8'd36
                    + 8'(cpa_pkg::cube_level(ch_g)) * 8'd6
                    + 8'(cpa_pkg::cube_level(ch_b));
    assign gray_dvd = cpa_pkg::VAL_W'(ch_r - 8'd8) * cpa_pkg::VAL_W'(24);

    // One restoring division step per cycle.
    assign div_shift    = {div_rem_reg, div_quo_reg[cpa_pkg::VAL_W-1]};
    assign div_take     = div_shift >= {1'b0, div_den_reg};
    assign div_rem_next = div_take ? 9'(div_shift - {1'b0, div_den_reg}) : div_shift[8:0];
    assign div_quo_next = {div_quo_reg[cpa_pkg::VAL_W-2:0], div_take};
    assign div_last     = (div_step_reg == cpa_pkg::STEP_W'(cpa_pkg::DIV_STEPS - 1));

    // Finished mapping of one color.
    always_comb
    begin
        res_store = 1'b0;
        res_val   = '0;
        unique case (state_reg)
            cpa_pkg::ST_PREP:
            begin
                if (cur[25])
                begin
                    res_store = 1'b1;
                    res_val   = cpa_pkg::MAP_DEFAULT;
                end
            end
            cpa_pkg::ST_CHECK:
            begin
                if (val_reg < cpa_pkg::LOW_PALETTE || val_reg < cpa_pkg::VAL_W'(cnt_eff))
                begin
                    res_store = 1'b1;
                    res_val   = val_reg[cpa_pkg::MAP_W-1:0];
                end
            end
            cpa_pkg::ST_DIVIDE:
            begin
                if (div_last && !div_gray_reg)
                begin
                    res_store = 1'b1;
                    res_val   = div_rem_next;
                end
            end
            default:
            begin
                res_store = 1'b0;
            end
        endcase
    end

    assign out_load = (state_reg == cpa_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg    <= cpa_pkg::COLOR_COUNT_RESET;
            pair_limit_reg     <= cpa_pkg::PAIR_LIMIT_RESET;
            colors_enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cpa_pkg::REG_COLOR_COUNT:    color_count_reg    <= cfg_data[cpa_pkg::CC_W-1:0];
                cpa_pkg::REG_PAIR_LIMIT:     pair_limit_reg     <= cfg_data[cpa_pkg::PL_W-1:0];
                cpa_pkg::REG_COLORS_ENABLED: colors_enabled_reg <= cfg_data[0];
                default:                     colors_enabled_reg <= colors_enabled_reg;
            endcase
        end
    end

    // Pair table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[used_cnt[cpa_pkg::IDX_W-1:0]] <= {back_reg, fore_reg};
        rd_data_reg <= mem[scan_reg[cpa_pkg::IDX_W-1:0]];
    end

    // Sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpa_pkg::ST_IDLE;
            next_free_reg <= cpa_pkg::CNT_W'(1);
            active_reg    <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                cpa_pkg::ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        fore_reg    <= in_fore;
                        back_reg    <= in_back;
                        created_reg <= 1'b0;
                        mf_reg      <= '0;
                        mb_reg      <= '0;
                        scan_reg    <= '0;
                        pend_reg    <= 1'b0;
                        if (!colors_enabled_reg)
                            state_reg <= cpa_pkg::ST_OUT;
                        else if (&in_fore && &in_back)
                        begin
                            active_reg <= '0;
                            state_reg  <= cpa_pkg::ST_OUT;
                        end
                        else
                            state_reg <= cpa_pkg::ST_SEARCH;
                    end
                end
                cpa_pkg::ST_SEARCH:
                begin
                    if (hit)
                    begin
                        active_reg <= cpa_pkg::PAIR_W'(hit_cnt);
                        state_reg  <= cpa_pkg::ST_OUT;
                    end
                    else if (scan_done)
                    begin
                        if (room)
                        begin
                            active_reg    <= cpa_pkg::PAIR_W'(next_free_reg);
                            next_free_reg <= next_free_reg + 1'b1;
                            created_reg   <= 1'b1;
                            sel_reg       <= 1'b0;
                            state_reg     <= cpa_pkg::ST_PREP;
                        end
                        else
                        begin
                            active_reg <= '0;
                            state_reg  <= cpa_pkg::ST_OUT;
                        end
                    end
                    else if (scan_reg < used_cnt)
                    begin
                        scan_reg     <= scan_reg + 1'b1;
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= scan_reg[cpa_pkg::IDX_W-1:0];
                    end
                    else
                        pend_reg <= 1'b0;
                end
                cpa_pkg::ST_PREP:
                begin
                    if (!cur[25])
                    begin
                        if (!is_rgb)
                        begin
                            val_reg   <= cur[cpa_pkg::VAL_W-1:0];
                            state_reg <= cpa_pkg::ST_CHECK;
                        end
                        else if (!is_gray)
                        begin
                            val_reg   <= cpa_pkg::VAL_W'(cube_idx);
                            state_reg <= cpa_pkg::ST_CHECK;
                        end
                        else if (ch_r < 8'd8)
                        begin
                            val_reg   <= cpa_pkg::LOW_PALETTE;
                            state_reg <= cpa_pkg::ST_CHECK;
                        end
                        else if (ch_r > 8'd248)
                        begin
                            val_reg   <= cpa_pkg::VAL_W'(231);
                            state_reg <= cpa_pkg::ST_CHECK;
                        end
                        else
                        begin
                            div_rem_reg  <= '0;
                            div_quo_reg  <= gray_dvd;
                            div_den_reg  <= cpa_pkg::GRAY_DIV;
                            div_step_reg <= '0;
                            div_gray_reg <= 1'b1;
                            state_reg    <= cpa_pkg::ST_DIVIDE;
                        end
                    end
                end
                cpa_pkg::ST_CHECK:
                begin
                    // Index of 16 or more and beyond the color count: reduce it modulo the count.
                    if (!res_store)
                    begin
                        div_rem_reg  <= '0;
                        div_quo_reg  <= val_reg;
                        div_den_reg  <= cnt_eff;
                        div_step_reg <= '0;
                        div_gray_reg <= 1'b0;
                        state_reg    <= cpa_pkg::ST_DIVIDE;
                    end
                end
                cpa_pkg::ST_DIVIDE:
                begin
                    div_rem_reg  <= div_rem_next;
                    div_quo_reg  <= div_quo_next;
                    div_step_reg <= div_step_reg + 1'b1;
                    if (div_last && div_gray_reg)
                    begin
                        val_reg   <= cpa_pkg::GRAY_BASE + div_quo_next;
                        state_reg <= cpa_pkg::ST_CHECK;
                    end
                end
                cpa_pkg::ST_OUT:
                begin
                    if (out_load)
                        state_reg <= cpa_pkg::ST_IDLE;
                end
                default:
                begin
                    state_reg <= cpa_pkg::ST_IDLE;
                end
            endcase

            // A mapped color moves on to the next color or to the output.
            if (res_store)
            begin
                if (!sel_reg)
                begin
                    mf_reg    <= res_val;
                    sel_reg   <= 1'b1;
                    state_reg <= cpa_pkg::ST_PREP;
                end
                else
                begin
                    mb_reg    <= res_val;
                    state_reg <= cpa_pkg::ST_OUT;
                end
            end

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pair_reg    <= active_reg;
            out_created_reg <= created_reg;
            out_mf_reg      <= mf_reg;
            out_mb_reg      <= mb_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_mb_reg, out_mf_reg, out_created_reg, out_pair_reg};

    // The free pointer stays within the table and only moves up by one.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg >= cpa_pkg::CNT_W'(1)
        && next_free_reg <= cpa_pkg::CNT_W'(cpa_pkg::TABLE_DEPTH))
        else $error("next free pair out of range");

    a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg))
        |-> (next_free_reg == $past(next_free_reg) + 1'b1))
        else $error("next free pair moved by more than one");

    // A compared entry was always written by an earlier allocation.
    a_scan_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpa_pkg::ST_SEARCH && pend_reg)
        |-> (cpa_pkg::CNT_W'(pend_idx_reg) < used_cnt))
        else $error("scan compared an unallocated entry");

    a_created_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_created_reg) |-> (out_pair_reg != '0))
        else $error("new pair reported as pair zero");

    a_no_create_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !out_created_reg) |-> (out_mf_reg == '0 && out_mb_reg == '0))
        else $error("mapped colors set without a new pair");

endmodule
